// ----- rtl/double_ended_ring_buffer_assert.svh -----
// Assertion macros used by the ring buffer control RTL.
`ifndef DOUBLE_ENDED_RING_BUFFER_ASSERT_SVH
`define DOUBLE_ENDED_RING_BUFFER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define DERB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checks that a condition holds in the cycle after a trigger, outside reset.
`define DERB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/derb_pkg.sv -----
// Shared constants, codes and types of the double-ended ring buffer.
package derb_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;
  localparam int ACTION_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int FILL_W     = 5;
  localparam int CFG_W      = 5;
  localparam int CAP_RESET  = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_READ_FRONT = 3'd4,
    ACT_READ_BACK  = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_RANGE   = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef struct packed {
    logic                has_data;
    status_t             status;
    logic                overwrote;
    logic [FILL_W-1:0]   fill_count;
    logic                is_full;
  } derb_side_t;

endpackage

// ----- rtl/derb_if.sv -----
// Request and result channel interfaces of the double-ended ring buffer.
interface derb_in_if import derb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VALUE_W-1:0]  write_value;
  logic [POS_W-1:0]    position;

  modport source (output valid, output action, output write_value, output position,
                  input ready);
  modport sink (input valid, input action, input write_value, input position,
                output ready);
endinterface

interface derb_out_if import derb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  read_value;
  logic [STATUS_W-1:0] status;
  logic                overwrote;
  logic [FILL_W-1:0]   fill_count;
  logic                is_full;

  modport source (output valid, output read_value, output status, output overwrote,
                  output fill_count, output is_full, input ready);
  modport sink (input valid, input read_value, input status, input overwrote,
                input fill_count, input is_full, output ready);
endinterface

// ----- rtl/derb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module derb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/derb_ctrl.sv -----
// Pointer, count and capacity control of the ring buffer, with slot access decode.
module derb_ctrl import derb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_W_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW      = $clog2(DEPTH + 1),
  localparam int CW        = (CNTW > CFG_W) ? CNTW : CFG_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [ACTION_W-1:0]   action,
  input  logic [VALUE_W-1:0]    write_value,
  input  logic [POS_W-1:0]      position,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [DATA_WIDTH-1:0] ram_wdata,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr,
  output derb_side_t            side
);

  localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic [CW-1:0] cap_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [AW-1:0] front_r;
  logic [AW-1:0] back_r;
  logic [CW-1:0] front_nxt;
  logic [CW-1:0] back_nxt;
  derb_side_t    side_r;
  derb_side_t    side_nxt;

  logic [CW-1:0] f;
  logic [CW-1:0] b;
  logic [CW:0]   f_inc;
  logic [CW:0]   b_inc;
  logic [CW-1:0] front_up;
  logic [CW-1:0] front_dn;
  logic [CW-1:0] back_up;
  logic [CW-1:0] back_dn;
  logic [CW:0]   rdf_sum;
  logic [CW:0]   rdb_sum;
  logic [CW-1:0] rdf_idx;
  logic [CW-1:0] rdb_idx;
  logic [CW-1:0] cfg_ext;
  logic [CW-1:0] cap_cfg;
  logic          no_cap;
  logic          no_data;
  logic          full;
  logic          out_of_range;
  logic          we_c;
  logic          re_c;
  logic [VALUE_W+DATA_WIDTH-1:0] wval_ext;

  assign f       = CW'(front_r);
  assign b       = CW'(back_r);
  assign f_inc   = (CW+1)'(f) + 1'b1;
  assign b_inc   = (CW+1)'(b) + 1'b1;
  assign front_up = (f_inc >= (CW+1)'(cap_r)) ? '0 : f_inc[CW-1:0];
  assign back_up  = (b_inc >= (CW+1)'(cap_r)) ? '0 : b_inc[CW-1:0];
  assign front_dn = (f == '0) ? cap_r - 1'b1 : f - 1'b1;
  assign back_dn  = (b == '0) ? cap_r - 1'b1 : b - 1'b1;

  assign rdf_sum = (CW+1)'(f) + (CW+1)'(position);
  assign rdb_sum = (CW+1)'(b) + (CW+1)'(cap_r) - 1'b1 - (CW+1)'(position);
  assign rdf_idx = (rdf_sum >= (CW+1)'(cap_r)) ? rdf_sum[CW-1:0] - cap_r : rdf_sum[CW-1:0];
  assign rdb_idx = (rdb_sum >= (CW+1)'(cap_r)) ? rdb_sum[CW-1:0] - cap_r : rdb_sum[CW-1:0];

  assign no_cap       = (cap_r == '0);
  assign no_data      = (cnt_r == '0) || no_cap;
  assign full         = (cnt_r >= cap_r);
  assign out_of_range = (CW'(position) >= cnt_r);

  assign cfg_ext = CW'(cfg_wdata);
  assign cap_cfg = (cfg_ext > CW'(DEPTH)) ? CW'(DEPTH) : cfg_ext;

  assign wval_ext = (VALUE_W+DATA_WIDTH)'(write_value);

  always_comb begin
    front_nxt = f;
    back_nxt  = b;
    cnt_nxt   = cnt_r;
    we_c      = 1'b0;
    re_c      = 1'b0;
    ram_waddr = front_r;
    ram_raddr = front_r;
    side_nxt.has_data  = 1'b0;
    side_nxt.status    = ST_OK;
    side_nxt.overwrote = 1'b0;
    case (action)
      ACT_PUSH_FRONT: begin
        if (no_cap) begin
          side_nxt.status = ST_DROPPED;
        end else begin
          we_c      = 1'b1;
          ram_waddr = front_dn[AW-1:0];
          front_nxt = front_dn;
          if (full) begin
            back_nxt           = front_dn;
            side_nxt.overwrote = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ACT_PUSH_BACK: begin
        if (no_cap) begin
          side_nxt.status = ST_DROPPED;
        end else begin
          we_c      = 1'b1;
          ram_waddr = back_r;
          back_nxt  = back_up;
          if (full) begin
            front_nxt          = back_up;
            side_nxt.overwrote = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ACT_POP_FRONT: begin
        if (no_data) begin
          side_nxt.status = ST_EMPTY;
        end else begin
          re_c              = 1'b1;
          ram_raddr         = front_r;
          front_nxt         = front_up;
          cnt_nxt           = cnt_r - 1'b1;
          side_nxt.has_data = 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (no_data) begin
          side_nxt.status = ST_EMPTY;
        end else begin
          re_c              = 1'b1;
          ram_raddr         = back_dn[AW-1:0];
          back_nxt          = back_dn;
          cnt_nxt           = cnt_r - 1'b1;
          side_nxt.has_data = 1'b1;
        end
      end
      ACT_READ_FRONT: begin
        if (no_data) begin
          side_nxt.status = ST_EMPTY;
        end else if (out_of_range) begin
          side_nxt.status = ST_RANGE;
        end else begin
          re_c              = 1'b1;
          ram_raddr         = rdf_idx[AW-1:0];
          side_nxt.has_data = 1'b1;
        end
      end
      ACT_READ_BACK: begin
        if (no_data) begin
          side_nxt.status = ST_EMPTY;
        end else if (out_of_range) begin
          side_nxt.status = ST_RANGE;
        end else begin
          re_c              = 1'b1;
          ram_raddr         = rdb_idx[AW-1:0];
          side_nxt.has_data = 1'b1;
        end
      end
      default: begin
      end
    endcase
    side_nxt.fill_count = FILL_W'(cnt_nxt);
    side_nxt.is_full    = (cnt_nxt == cap_r);
  end

  assign ram_we    = acc && we_c;
  assign ram_re    = acc && re_c;
  assign ram_wdata = wval_ext[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CW'(CAP_RST);
      cnt_r   <= '0;
      front_r <= '0;
      back_r  <= '0;
    end else if (cfg_we) begin
      cap_r   <= cap_cfg;
      cnt_r   <= '0;
      front_r <= '0;
      back_r  <= '0;
    end else if (acc) begin
      cnt_r   <= cnt_nxt;
      front_r <= front_nxt[AW-1:0];
      back_r  <= back_nxt[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      side_r <= side_nxt;
    end
  end

  assign side = side_r;

`include "double_ended_ring_buffer_assert.svh"

`DERB_ASSERT(a_count_le_cap, cnt_r <= cap_r, "element count exceeds capacity")
`DERB_ASSERT(a_ptrs_in_ring, (front_r == '0 && back_r == '0) || (CW'(front_r) < cap_r && CW'(back_r) < cap_r), "pointer outside ring")
`DERB_ASSERT_NEXT(a_push_grows, acc && !cfg_we && !no_cap && !full && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK), cnt_r == CW'($past(cnt_r) + 1'b1), "push into free slot did not grow count")
`DERB_ASSERT_NEXT(a_cfg_empties, cfg_we, cnt_r == '0 && front_r == '0 && back_r == '0, "capacity write did not empty buffer")

endmodule

// ----- rtl/double_ended_ring_buffer.sv -----
// A result is registered in the control stage and slot RAM read data, then in the output stage.
// Throughput: one request per cycle unless stalled, limited by one read and one write RAM port.
// The output stage holds a result under back-pressure while the next request is taken.
// Reset empties the buffer and sets the capacity to 16, limited to DEPTH.
// Slot storage is not cleared by reset.
// Top level of the double-ended ring buffer with overwrite on full.
module double_ended_ring_buffer import derb_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  derb_in_if.sink          in_chan,
  derb_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  acc;
  logic                  adv;
  logic                  v1_r;
  logic                  v1_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [VALUE_W+DATA_WIDTH-1:0] rdata_ext;
  derb_side_t            side;
  derb_side_t            res_r;
  logic [VALUE_W-1:0]    value_r;

  derb_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .action      (in_chan.action),
    .write_value (in_chan.write_value),
    .position    (in_chan.position),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .side        (side)
  );

  derb_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign adv           = v1_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !v1_r || adv;
  assign acc           = in_chan.valid && in_chan.ready;
  assign v1_nxt        = acc ? 1'b1 : (adv ? 1'b0 : v1_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  assign rdata_ext     = (VALUE_W+DATA_WIDTH)'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r   <= side;
      value_r <= side.has_data ? rdata_ext[VALUE_W-1:0] : '0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.read_value = value_r;
  assign out_chan.status     = res_r.status;
  assign out_chan.overwrote  = res_r.overwrote;
  assign out_chan.fill_count = res_r.fill_count;
  assign out_chan.is_full    = res_r.is_full;

endmodule
